// ----- rtl/core/tmac_pkg.sv -----
// ----------------------------------------------------------------------------
// tmac_pkg
// Shared types, item kinds and arithmetic helpers for the int8 tile MAC.
// ----------------------------------------------------------------------------
`default_nettype none

package tmac_pkg;

  // Columns carried by one payload (four 64-bit words, two columns each)
  localparam int unsigned PAY_COLS = 8;

  // Item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_MAC  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [31:0] a_quad;
    logic [63:0] pay0;
    logic [63:0] pay1;
    logic [63:0] pay2;
    logic [63:0] pay3;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [3:0]         out_row;
    logic signed [31:0] acc0;
    logic signed [31:0] acc1;
    logic signed [31:0] acc2;
    logic signed [31:0] acc3;
    logic signed [31:0] acc4;
    logic signed [31:0] acc5;
    logic signed [31:0] acc6;
    logic signed [31:0] acc7;
  } out_item_t;

  // Command token passed from cell to cell
  typedef struct packed {
    logic        vld;
    logic        mode;
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [31:0] a_quad;
  } tok_t;

  // Per-cell status back to the controller
  typedef struct packed {
    logic done;
    logic rd_vld;
  } cell_stat_t;

  // Clamp a pair sum to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tmac_ram.sv -----
// ----------------------------------------------------------------------------
// tmac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/tmac_cell.sv -----
// ----------------------------------------------------------------------------
// tmac_cell
// One tile column: holds that column's accumulators for every row, forms the
// s8 x u8 quad dot product and updates, loads or reads the addressed row.
// ----------------------------------------------------------------------------
`default_nettype none

module tmac_cell #(
  parameter int unsigned TILE_ROWS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tmac_pkg::tok_t      tok_i,
  input  wire logic [31:0]         b_word_i,
  output tmac_pkg::tok_t           tok_o,
  output logic [31:0]              acc_o,
  output tmac_pkg::cell_stat_t     stat_o
);

  localparam int unsigned AW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

  tmac_pkg::tok_t     s1_q;
  logic signed [16:0] prod_q [4];
  logic [7:0]         row0_ext;
  logic [7:0]         row1_ext;
  logic [AW-1:0]      addr0;
  logic [AW-1:0]      addr1;
  logic [31:0]        rdata;
  logic signed [17:0] lo_sum;
  logic signed [17:0] hi_sum;
  logic signed [15:0] lo_sat;
  logic signed [15:0] hi_sat;
  logic signed [16:0] dot;
  logic [31:0]        acc_new;
  logic               is_load;
  logic               is_mac;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;

  // row addresses of the entering token and of the token in stage 1
  assign row0_ext = {4'd0, tok_i.row};
  assign row1_ext = {4'd0, s1_q.row};
  assign addr0    = row0_ext[AW-1:0];
  assign addr1    = row1_ext[AW-1:0];

  // stage 1 token, also the hand-off to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= tok_i;
    end
  end

  // stage 0: four signed x unsigned byte products
  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      for (int t = 0; t < 4; t++) begin
        prod_q[t] <= $signed(tok_i.a_quad[8*t +: 8]) * $signed({1'b0, b_word_i[8*t +: 8]});
      end
    end
  end

  // stage 1: pair sums, saturation, accumulate with wrap
  always_comb begin
    lo_sum  = {prod_q[0][16], prod_q[0]} + {prod_q[1][16], prod_q[1]};
    hi_sum  = {prod_q[2][16], prod_q[2]} + {prod_q[3][16], prod_q[3]};
    lo_sat  = tmac_pkg::sat16(lo_sum);
    hi_sat  = tmac_pkg::sat16(hi_sum);
    dot     = {lo_sat[15], lo_sat} + {hi_sat[15], hi_sat};
    acc_new = rdata + {{15{dot[16]}}, dot};
  end

  // write port: loads in stage 0, accumulates in stage 1
  assign is_load = tok_i.vld && (tok_i.kind == tmac_pkg::KIND_LOAD);
  assign is_mac  = s1_q.vld && (s1_q.kind == tmac_pkg::KIND_MAC);
  assign we      = is_load || is_mac;
  assign waddr   = is_load ? addr0 : addr1;
  assign wdata   = is_load ? (tok_i.mode ? b_word_i : 32'd0) : acc_new;

  tmac_ram #(
    .WIDTH (32),
    .DEPTH (TILE_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (tok_i.vld),
    .raddr_i (addr0),
    .rdata_o (rdata)
  );

  assign tok_o         = s1_q;
  assign acc_o         = rdata;
  assign stat_o.done   = s1_q.vld;
  assign stat_o.rd_vld = s1_q.vld && (s1_q.kind == tmac_pkg::KIND_READ);

endmodule

`default_nettype wire

// ----- rtl/core/int8_tile_mac_16x8.sv -----
// ----------------------------------------------------------------------------
// int8_tile_mac_16x8
// Tile of int32 accumulators for a s8 x u8 matrix product, built as a chain
// of column cells.
// ----------------------------------------------------------------------------
// One transaction at a time. A command token enters the first column cell the
// cycle after acceptance and moves one cell per cycle; each cell works on it
// in a product stage, then an accumulator RAM read-modify-write stage. The
// chain holds N = min(TILE_COLS, 8) cells. A load or multiply frees the input
// once the last cell is done; a read then waits in the output state until its
// result is loaded into the output register. Kind 3 and rows beyond the tile
// send no token down the chain (a read still passes the output state). The
// chain length sets how long a transaction holds the tile. The output register
// holds a finished read while the next transaction is accepted; a read waits
// in the output state while the previous result is still held. No clearing
// pass: a row must be loaded before it is accumulated into or read.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_tile_mac_16x8 #(
  parameter int unsigned TILE_ROWS = 16,
  parameter int unsigned TILE_COLS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tmac_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tmac_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i
);

  localparam int unsigned NCELL =
    (TILE_COLS < tmac_pkg::PAY_COLS) ? TILE_COLS : tmac_pkg::PAY_COLS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic                 mode_q;
  tmac_pkg::in_item_t   item_q;
  tmac_pkg::tok_t       tok0_q;
  tmac_pkg::out_item_t  out_data_q;
  logic                 out_valid_q;
  logic [31:0]          res_q [tmac_pkg::PAY_COLS];

  logic                 accept;
  logic                 in_tile;
  logic                 kind_ok;
  logic                 inject;
  logic                 last_done;
  logic                 out_load;
  logic [3:0][63:0]     pay_w;
  logic [NCELL-1:0]     tok_vld;

  tmac_pkg::tok_t       tok_w  [NCELL+1];
  logic [31:0]          acc_w  [NCELL];
  tmac_pkg::cell_stat_t stat_w [NCELL];

  // accept and dispatch
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_tile    = (32'(in_data_i.row) < TILE_ROWS);
  assign kind_ok    = (in_data_i.kind == tmac_pkg::KIND_LOAD) ||
                      (in_data_i.kind == tmac_pkg::KIND_MAC)  ||
                      (in_data_i.kind == tmac_pkg::KIND_READ);
  assign inject     = accept && kind_ok && in_tile;
  assign last_done  = stat_w[NCELL-1].done;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // accumulate mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // control FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (inject) begin
          state_d = ST_RUN;
        end else if (accept && (in_data_i.kind == tmac_pkg::KIND_READ)) begin
          state_d = ST_OUT;
        end
      end
      ST_RUN: begin
        if (last_done) begin
          state_d = (item_q.kind == tmac_pkg::KIND_READ) ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tok0_q  <= '0;
    end else begin
      state_q       <= state_d;
      tok0_q.vld    <= inject;
      tok0_q.mode   <= mode_q;
      tok0_q.kind   <= in_data_i.kind;
      tok0_q.row    <= in_data_i.row;
      tok0_q.a_quad <= in_data_i.a_quad;
    end
  end

  // held transaction payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  // read result collection; columns without a cell stay zero
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int c = 0; c < tmac_pkg::PAY_COLS; c++) begin
        res_q[c] <= 32'd0;
      end
    end else begin
      for (int c = 0; c < NCELL; c++) begin
        if (stat_w[c].rd_vld) begin
          res_q[c] <= acc_w[c];
        end
      end
    end
  end

  // column cell chain
  assign pay_w    = {item_q.pay3, item_q.pay2, item_q.pay1, item_q.pay0};
  assign tok_w[0] = tok0_q;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    tmac_cell #(
      .TILE_ROWS (TILE_ROWS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_w[c]),
      .b_word_i (pay_w[c >> 1][(c & 1) * 32 +: 32]),
      .tok_o    (tok_w[c+1]),
      .acc_o    (acc_w[c]),
      .stat_o   (stat_w[c])
    );
    assign tok_vld[c] = tok_w[c].vld;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.out_row <= item_q.row;
      out_data_q.acc0    <= res_q[0];
      out_data_q.acc1    <= res_q[1];
      out_data_q.acc2    <= res_q[2];
      out_data_q.acc3    <= res_q[3];
      out_data_q.acc4    <= res_q[4];
      out_data_q.acc5    <= res_q[5];
      out_data_q.acc6    <= res_q[6];
      out_data_q.acc7    <= res_q[7];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // only one token travels the chain at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one command token in the cell chain");

  // the last cell finishes only while the controller waits for it
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_done |-> (state_q == ST_RUN))
    else $error("cell chain finished outside the run state");

  // a new result is presented only after the output state
  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result presented without passing the output state");

  // no transaction accepted while the chain is busy
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok0_q.vld || last_done) |-> !in_ready_o)
    else $error("input accepted while a command is in flight");
`endif

endmodule

`default_nettype wire
